// ===== sv/mfft_pkg.sv =====
package mfft_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
    logic [7:0] received_length;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] field_role;
    logic [6:0] field_offset;
    logic [2:0] error_code;
    logic [6:0] payload_length;
    logic       last_byte;
  } out_t;

  // frame context handed from the tracker to the field classifier
  typedef struct packed {
    logic [15:0] control_word;
    logic [7:0]  frame_length;
    logic [4:0]  header_length;
  } frame_ctx_t;

  localparam logic [3:0] ROLE_LEN     = 4'd0;
  localparam logic [3:0] ROLE_CTRL    = 4'd1;
  localparam logic [3:0] ROLE_SEQ     = 4'd2;
  localparam logic [3:0] ROLE_DPAN    = 4'd3;
  localparam logic [3:0] ROLE_DSHORT  = 4'd4;
  localparam logic [3:0] ROLE_DLONG   = 4'd5;
  localparam logic [3:0] ROLE_SPAN    = 4'd6;
  localparam logic [3:0] ROLE_SSHORT  = 4'd7;
  localparam logic [3:0] ROLE_SLONG   = 4'd8;
  localparam logic [3:0] ROLE_SFSPEC  = 4'd9;
  localparam logic [3:0] ROLE_CMD     = 4'd10;
  localparam logic [3:0] ROLE_PAYLOAD = 4'd11;
  localparam logic [3:0] ROLE_FCS     = 4'd12;
  localparam logic [3:0] ROLE_DISCARD = 4'd13;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_LENGTH     = 3'd1;
  localparam logic [2:0] ERR_DEST_MODE  = 3'd2;
  localparam logic [2:0] ERR_SRC_MODE   = 3'd3;
  localparam logic [2:0] ERR_FRAME_TYPE = 3'd4;
  localparam logic [2:0] ERR_OVERRUN    = 3'd5;

  localparam logic [1:0] ADDR_NONE     = 2'd0;
  localparam logic [1:0] ADDR_RESERVED = 2'd1;
  localparam logic [1:0] ADDR_SHORT    = 2'd2;
  localparam logic [1:0] ADDR_LONG     = 2'd3;

  localparam logic [2:0] FT_BEACON  = 3'd0;
  localparam logic [2:0] FT_COMMAND = 3'd3;

  localparam logic CFG_MIN_LEN = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [7:0] MIN_LEN_RESET = 8'd5;
  localparam logic [7:0] MAX_LEN_RESET = 8'd128;

  function automatic logic [1:0] dest_mode(input logic [15:0] cw);
    return cw[11:10];
  endfunction

  function automatic logic [1:0] src_mode(input logic [15:0] cw);
    return cw[15:14];
  endfunction

  function automatic logic [2:0] frame_type(input logic [15:0] cw);
    return cw[2:0];
  endfunction

endpackage

// ===== sv/mfft_classify.sv =====
module mfft_classify (
  input  logic [7:0]              pos,
  input  mfft_pkg::frame_ctx_t    ctx,
  output logic [3:0]              role,
  output logic [6:0]              offset
);

  logic [1:0] dm;
  logic [1:0] sm;
  logic [2:0] ft;
  logic       has_src;
  logic [7:0] dst_len;
  logic [7:0] src_len;
  logic [7:0] tail_len;
  logic [7:0] dst_end;
  logic [7:0] src_end;
  logic [7:0] diff;
  logic [8:0] fcs_diff;

  always_comb begin
    dm = mfft_pkg::dest_mode(ctx.control_word);
    sm = mfft_pkg::src_mode(ctx.control_word);
    ft = mfft_pkg::frame_type(ctx.control_word);
    has_src = (sm == mfft_pkg::ADDR_SHORT) || (sm == mfft_pkg::ADDR_LONG);
    dst_len = (dm == mfft_pkg::ADDR_LONG) ? 8'd8 :
              (dm == mfft_pkg::ADDR_SHORT) ? 8'd2 : 8'd0;
    src_len = (sm == mfft_pkg::ADDR_LONG) ? 8'd8 : 8'd2;
    tail_len = (ft == mfft_pkg::FT_BEACON) ? 8'd2 :
               (ft == mfft_pkg::FT_COMMAND) ? 8'd1 : 8'd0;
    dst_end = 8'd6 + dst_len;
    src_end = has_src ? (dst_end + 8'd2 + src_len) : dst_end;
    diff = 8'd0;
    fcs_diff = 9'd0;
    role = mfft_pkg::ROLE_PAYLOAD;
    offset = 7'd0;

    if (pos == 8'd3) begin
      role = mfft_pkg::ROLE_SEQ;
    end else if (pos < 8'd6) begin
      role = mfft_pkg::ROLE_DPAN;
      diff = pos - 8'd4;
      offset = diff[6:0];
    end else if (pos < dst_end) begin
      role = (dm == mfft_pkg::ADDR_LONG) ? mfft_pkg::ROLE_DLONG : mfft_pkg::ROLE_DSHORT;
      diff = pos - 8'd6;
      offset = diff[6:0];
    end else if (has_src && (pos < dst_end + 8'd2)) begin
      role = mfft_pkg::ROLE_SPAN;
      diff = pos - dst_end;
      offset = diff[6:0];
    end else if (has_src && (pos < src_end)) begin
      role = (sm == mfft_pkg::ADDR_LONG) ? mfft_pkg::ROLE_SLONG : mfft_pkg::ROLE_SSHORT;
      diff = pos - dst_end - 8'd2;
      offset = diff[6:0];
    end else if (pos < src_end + tail_len) begin
      if (ft == mfft_pkg::FT_BEACON) begin
        role = mfft_pkg::ROLE_SFSPEC;
        diff = pos - src_end;
        offset = diff[6:0];
      end else begin
        role = mfft_pkg::ROLE_CMD;
      end
    end else if (({1'b0, pos} + 9'd2) < {1'b0, ctx.frame_length}) begin
      role = mfft_pkg::ROLE_PAYLOAD;
      diff = pos - {3'b000, ctx.header_length};
      offset = diff[7] ? 7'd127 : diff[6:0];
    end else begin
      role = mfft_pkg::ROLE_FCS;
      fcs_diff = {1'b0, pos} + 9'd2 - {1'b0, ctx.frame_length};
      offset = fcs_diff[6:0];
    end
  end

endmodule

// ===== sv/mfft_tracker.sv =====
module mfft_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  mfft_pkg::in_t     item,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output mfft_pkg::out_t    res
);

  logic [7:0]  min_len_r;
  logic [7:0]  max_len_r;
  logic [7:0]  pos_r,   pos_nxt;
  logic [7:0]  flen_r,  flen_nxt;
  logic [15:0] ctrl_r,  ctrl_nxt;
  logic [2:0]  err_r,   err_nxt;
  logic [4:0]  hdr_r,   hdr_nxt;

  logic [8:0]  len9;
  logic        bad_len;
  logic [15:0] cw_full;
  logic [1:0]  dm;
  logic [1:0]  sm;
  logic [2:0]  ft;
  logic [4:0]  cnt;
  logic [7:0]  pl_diff;
  logic [3:0]  cls_role;
  logic [6:0]  cls_off;
  mfft_pkg::frame_ctx_t ctx;

  assign ctx.control_word  = ctrl_r;
  assign ctx.frame_length  = flen_r;
  assign ctx.header_length = hdr_r;

  mfft_classify u_classify (
    .pos    (pos_r),
    .ctx    (ctx),
    .role   (cls_role),
    .offset (cls_off)
  );

  // header length from the complete frame control
  always_comb begin
    cw_full = {item.byte_value, ctrl_r[7:0]};
    dm = mfft_pkg::dest_mode(cw_full);
    sm = mfft_pkg::src_mode(cw_full);
    ft = mfft_pkg::frame_type(cw_full);
    cnt = 5'd4;
    case (dm)
      mfft_pkg::ADDR_NONE:  cnt = cnt + 5'd2;
      mfft_pkg::ADDR_SHORT: cnt = cnt + 5'd4;
      mfft_pkg::ADDR_LONG:  cnt = cnt + 5'd10;
      default:              cnt = cnt;
    endcase
    case (sm)
      mfft_pkg::ADDR_SHORT: cnt = cnt + 5'd4;
      mfft_pkg::ADDR_LONG:  cnt = cnt + 5'd10;
      default:              cnt = cnt;
    endcase
    if (ft == mfft_pkg::FT_BEACON) begin
      cnt = cnt + 5'd2;
    end else if (ft == mfft_pkg::FT_COMMAND) begin
      cnt = cnt + 5'd1;
    end
  end

  always_comb begin
    len9 = {1'b0, item.byte_value} + 9'd1;
    bad_len = ((item.received_length != 8'd0) && ({1'b0, item.received_length} != len9)) ||
              (len9 < {1'b0, min_len_r}) || (len9 >= {1'b0, max_len_r});
    pos_nxt  = pos_r;
    flen_nxt = flen_r;
    ctrl_nxt = ctrl_r;
    err_nxt  = err_r;
    hdr_nxt  = hdr_r;
    pl_diff  = 8'd0;

    res.byte_out       = item.byte_value;
    res.field_role     = mfft_pkg::ROLE_DISCARD;
    res.field_offset   = 7'd0;
    res.payload_length = 7'd0;
    res.last_byte      = 1'b0;

    if (item.frame_start) begin
      ctrl_nxt = 16'd0;
      hdr_nxt  = 5'd0;
      pos_nxt  = 8'd1;
      res.field_role = mfft_pkg::ROLE_LEN;
      if (bad_len) begin
        err_nxt  = mfft_pkg::ERR_LENGTH;
        flen_nxt = 8'd0;
      end else begin
        flen_nxt = len9[7:0];
        err_nxt  = (len9 < 9'd3) ? mfft_pkg::ERR_OVERRUN : mfft_pkg::ERR_OK;
        res.last_byte = (len9 == 9'd1);
      end
    end else begin
      if (pos_r != 8'd255) begin
        pos_nxt = pos_r + 8'd1;
      end
      if (pos_r < flen_r) begin
        res.last_byte = (({1'b0, pos_r} + 9'd1) == {1'b0, flen_r});
        if (err_r == mfft_pkg::ERR_OK) begin
          if (pos_r == 8'd1) begin
            ctrl_nxt = {ctrl_r[15:8], item.byte_value};
            res.field_role = mfft_pkg::ROLE_CTRL;
          end else if (pos_r == 8'd2) begin
            ctrl_nxt = cw_full;
            res.field_role = mfft_pkg::ROLE_CTRL;
            res.field_offset = 7'd1;
            // checks in priority order: dest, source, type, overrun
            if (dm == mfft_pkg::ADDR_RESERVED) begin
              err_nxt = mfft_pkg::ERR_DEST_MODE;
            end else if (sm == mfft_pkg::ADDR_RESERVED) begin
              err_nxt = mfft_pkg::ERR_SRC_MODE;
            end else if (ft > mfft_pkg::FT_COMMAND) begin
              err_nxt = mfft_pkg::ERR_FRAME_TYPE;
            end else if (({3'b000, cnt} + 8'd2) > flen_r) begin
              err_nxt = mfft_pkg::ERR_OVERRUN;
            end else begin
              hdr_nxt = cnt;
            end
          end else if (pos_r >= 8'd3) begin
            res.field_role   = cls_role;
            res.field_offset = cls_off;
          end
          if ((err_nxt == mfft_pkg::ERR_OK) && (pos_r >= 8'd2)) begin
            pl_diff = flen_r - {3'b000, hdr_nxt} - 8'd2;
            res.payload_length = pl_diff[7] ? 7'd127 : pl_diff[6:0];
          end
        end
      end
    end
    res.error_code = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= mfft_pkg::MIN_LEN_RESET;
      max_len_r <= mfft_pkg::MAX_LEN_RESET;
      pos_r     <= 8'd0;
      flen_r    <= 8'd0;
      ctrl_r    <= 16'd0;
      err_r     <= mfft_pkg::ERR_OK;
      hdr_r     <= 5'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mfft_pkg::CFG_MIN_LEN) begin
          min_len_r <= cfg_wdata;
        end else begin
          max_len_r <= cfg_wdata;
        end
      end
      if (acc) begin
        pos_r  <= pos_nxt;
        flen_r <= flen_nxt;
        ctrl_r <= ctrl_nxt;
        err_r  <= err_nxt;
        hdr_r  <= hdr_nxt;
      end
    end
  end

endmodule

// ===== sv/mfft_outbuf.sv =====
module mfft_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  mfft_pkg::out_t    res,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output mfft_pkg::out_t    out_data
);

  logic           out_valid_r;
  mfft_pkg::out_t out_data_r;
  logic           skid_valid_r;
  mfft_pkg::out_t skid_data_r;
  logic           drain;

  assign drain     = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      out_valid_r  <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

endmodule

// ===== sv/mac_frame_field_tagger.sv =====
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------
// in       | in_valid / in_stall    | in_data  (mfft_pkg::in_t)
// out      | out_valid / out_stall  | out_data (mfft_pkg::out_t)
// cfg      | cfg_we                 | cfg_index, cfg_wdata
//
// one byte per cycle unless in_stall; a result is registered to out_data unless out is stalled
// field decode is a single pass off the frame state registers into the output register
// a two-entry output buffer (register plus skid) takes a beat while a result waits
// in_stall rises only when both entries are full
// rst_n is synchronous: clears frame state, loads length limits 5 and 128
module mac_frame_field_tagger (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfft_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfft_pkg::out_t    out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic           acc;
  mfft_pkg::out_t res;

  assign acc = in_valid && !in_stall;

  mfft_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  mfft_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .res       (res),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_skid_implies_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry held with empty output register");

  a_discard_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.field_role == mfft_pkg::ROLE_DISCARD)) |->
      (out_data.field_offset == 7'd0) && (out_data.payload_length == 7'd0))
    else $error("discarded beat carries offset or payload length");

  a_error_no_payload : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code != mfft_pkg::ERR_OK)) |->
      (out_data.payload_length == 7'd0))
    else $error("payload length reported on errored frame");

  a_last_needs_length : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_byte) |-> (out_data.error_code != mfft_pkg::ERR_LENGTH))
    else $error("last byte flagged on rejected length");

endmodule
